FILE: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define ASSERT_HOLDS(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: hdl/pfc_adm_pkg.sv
// types and constants of the pfc/ecn egress admission unit
package pfc_adm_pkg;

   localparam int CNT_W     = 14;
   localparam int PORT_FW   = 4;
   localparam int ACTION_W  = 2;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_CAPACITY   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_THRESHOLD  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESUME_THRESHOLD = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ECN_CUTOFF       = 4'd3;

   localparam logic [CNT_W-1:0] RST_QUEUE_CAPACITY   = 14'd8192;
   localparam logic [CNT_W-1:0] RST_PAUSE_THRESHOLD  = 14'd3584;
   localparam logic [CNT_W-1:0] RST_RESUME_THRESHOLD = 14'd819;
   localparam logic [CNT_W-1:0] RST_ECN_CUTOFF       = 14'd1024;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ARRIVAL     = 2'd0,
      ACT_DEQUEUE     = 2'd1,
      ACT_PAUSE_DONE  = 2'd2,
      ACT_RESUME_DONE = 2'd3
   } action_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic step_pause;
      logic step_resume;
      logic step_data;
      logic step_deq;
      logic step_flag;
      logic wr_src;
      logic wr_dst;
   } cmd_type;

   typedef struct packed {
      logic       in_range;
      action_type action;
   } stat_type;

endpackage

FILE: hdl/pfc_adm_ctrl.sv
// sequencer for one request: load, admission steps, write-back, response
module pfc_adm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  pfc_adm_pkg::stat_type stat,
   output pfc_adm_pkg::cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import pfc_adm_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_LOAD   = 9'b000000010,
      S_PAUSE  = 9'b000000100,
      S_RESUME = 9'b000001000,
      S_DATA   = 9'b000010000,
      S_DEQ    = 9'b000100000,
      S_FLAG   = 9'b001000000,
      S_WRSRC  = 9'b010000000,
      S_WRDST  = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_LOAD;
         end
         S_LOAD: begin
            if (!stat.in_range) begin
               state_in = S_WRDST;
            end else begin
               case (stat.action)
                  ACT_ARRIVAL: state_in = S_PAUSE;
                  ACT_DEQUEUE: state_in = S_DEQ;
                  default:     state_in = S_FLAG;
               endcase
            end
         end
         S_PAUSE:  state_in = S_RESUME;
         S_RESUME: state_in = S_DATA;
         S_DATA:   state_in = S_WRSRC;
         S_DEQ:    state_in = S_WRSRC;
         S_FLAG:   state_in = S_WRSRC;
         S_WRSRC:  state_in = S_WRDST;
         S_WRDST:  state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_WRDST);

   assign cmd.capture     = (state_ff == S_IDLE) && start;
   assign cmd.load        = (state_ff == S_LOAD);
   assign cmd.step_pause  = (state_ff == S_PAUSE);
   assign cmd.step_resume = (state_ff == S_RESUME);
   assign cmd.step_data   = (state_ff == S_DATA);
   assign cmd.step_deq    = (state_ff == S_DEQ);
   assign cmd.step_flag   = (state_ff == S_FLAG);
   assign cmd.wr_src      = (state_ff == S_WRSRC);
   assign cmd.wr_dst      = (state_ff == S_WRDST);

endmodule

FILE: hdl/pfc_adm_dp.sv
// datapath: config registers, occupancy and flag memories, admission arithmetic
module pfc_adm_dp #(
   parameter int PORTS       = 16,
   parameter int QUEUE_DEPTH = 8192
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pfc_adm_pkg::cmd_type                   cmd,
   output pfc_adm_pkg::stat_type                  stat,
   input  logic                                   csr_we,
   input  logic [pfc_adm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pfc_adm_pkg::CNT_W-1:0]          csr_data,
   input  logic [pfc_adm_pkg::ACTION_W-1:0]       req_action,
   input  logic [pfc_adm_pkg::PORT_FW-1:0]        req_dest_port,
   input  logic [pfc_adm_pkg::PORT_FW-1:0]        req_source_port,
   output logic                                   rsp_ecn_mark,
   output logic                                   rsp_pause_out,
   output logic                                   rsp_resume_out,
   output logic                                   rsp_control_dropped,
   output logic                                   rsp_data_dropped,
   output logic                                   rsp_frame_sent,
   output logic [pfc_adm_pkg::CNT_W-1:0]          rsp_occupancy_after
);
   import pfc_adm_pkg::*;

   localparam int PORT_W = $clog2(PORTS);

   // memories
   logic [CNT_W-1:0]     occ_mem  [PORTS];
   logic [2*PORTS-1:0]   flag_mem [PORTS];
   logic [CNT_W-1:0]     rd_dst_ff;
   logic [CNT_W-1:0]     rd_src_ff;
   logic [2*PORTS-1:0]   rd_flag_ff;

   // valid bits
   logic [PORTS-1:0]     occ_valid_ff, occ_valid_in;
   logic [PORTS-1:0]     flag_valid_ff, flag_valid_in;

   // config registers
   logic [CNT_W-1:0]     capacity_ff, capacity_in;
   logic [CNT_W-1:0]     pause_th_ff, pause_th_in;
   logic [CNT_W-1:0]     resume_th_ff, resume_th_in;
   logic [CNT_W-1:0]     ecn_cut_ff, ecn_cut_in;

   // request and working registers
   action_type           action_ff, action_in;
   logic [PORT_FW-1:0]   dst_ff, dst_in;
   logic [PORT_FW-1:0]   src_ff, src_in;
   logic                 in_range_ff, in_range_in;
   logic [CNT_W-1:0]     dst_cnt_ff, dst_cnt_in;
   logic [CNT_W-1:0]     src_cnt_ff, src_cnt_in;
   logic [PORTS-1:0]     p_row_ff, p_row_in;
   logic [PORTS-1:0]     r_row_ff, r_row_in;
   logic                 ecn_ff, ecn_in;
   logic                 pause_ff, pause_in;
   logic                 resume_ff, resume_in;
   logic                 cdrop_ff, cdrop_in;
   logic                 ddrop_ff, ddrop_in;
   logic                 sent_ff, sent_in;

   logic [PORT_W-1:0]    req_dst_idx;
   logic [PORT_W-1:0]    req_src_idx;
   logic [PORT_W-1:0]    dst_idx;
   logic [PORT_W-1:0]    src_idx;
   logic                 same_port;
   logic [CNT_W-1:0]     cap_eff;
   logic                 occ_we;
   logic [PORT_W-1:0]    occ_waddr;
   logic [CNT_W-1:0]     occ_wdata;
   logic                 flag_we;

   assign req_dst_idx = PORT_W'(req_dest_port);
   assign req_src_idx = PORT_W'(req_source_port);
   assign dst_idx     = PORT_W'(dst_ff);
   assign src_idx     = PORT_W'(src_ff);
   assign same_port   = (dst_ff == src_ff);
   assign cap_eff     = (32'(capacity_ff) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH) : capacity_ff;

   // config writes
   always_comb begin
      capacity_in  = capacity_ff;
      pause_th_in  = pause_th_ff;
      resume_th_in = resume_th_ff;
      ecn_cut_in   = ecn_cut_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_QUEUE_CAPACITY:   capacity_in  = csr_data;
            CSR_PAUSE_THRESHOLD:  pause_th_in  = csr_data;
            CSR_RESUME_THRESHOLD: resume_th_in = csr_data;
            CSR_ECN_CUTOFF:       ecn_cut_in   = csr_data;
            default: ;
         endcase
      end
   end

   // admission steps
   always_comb begin
      action_in   = action_ff;
      dst_in      = dst_ff;
      src_in      = src_ff;
      in_range_in = in_range_ff;
      dst_cnt_in  = dst_cnt_ff;
      src_cnt_in  = src_cnt_ff;
      p_row_in    = p_row_ff;
      r_row_in    = r_row_ff;
      ecn_in      = ecn_ff;
      pause_in    = pause_ff;
      resume_in   = resume_ff;
      cdrop_in    = cdrop_ff;
      ddrop_in    = ddrop_ff;
      sent_in     = sent_ff;

      if (cmd.capture) begin
         action_in   = action_type'(req_action);
         dst_in      = req_dest_port;
         src_in      = req_source_port;
         in_range_in = (32'(req_dest_port) < PORTS) && (32'(req_source_port) < PORTS);
      end

      if (cmd.load) begin
         dst_cnt_in = occ_valid_ff[dst_idx] ? rd_dst_ff : '0;
         src_cnt_in = occ_valid_ff[src_idx] ? rd_src_ff : '0;
         p_row_in   = flag_valid_ff[dst_idx] ? rd_flag_ff[PORTS-1:0] : '0;
         r_row_in   = flag_valid_ff[dst_idx] ? rd_flag_ff[2*PORTS-1:PORTS] : '0;
         ecn_in     = 1'b0;
         pause_in   = 1'b0;
         resume_in  = 1'b0;
         cdrop_in   = 1'b0;
         ddrop_in   = 1'b0;
         sent_in    = 1'b0;
      end

      if (cmd.step_pause) begin
         ecn_in = (dst_cnt_ff > ecn_cut_ff);
         if ((dst_cnt_ff >= pause_th_ff) && !p_row_ff[src_idx]) begin
            p_row_in[src_idx] = 1'b1;
            pause_in          = 1'b1;
            if (src_cnt_ff < cap_eff) begin
               src_cnt_in = src_cnt_ff + 1'b1;
               if (same_port) dst_cnt_in = src_cnt_ff + 1'b1;
            end else begin
               cdrop_in = 1'b1;
            end
         end
      end

      if (cmd.step_resume) begin
         if ((dst_cnt_ff < resume_th_ff) && !r_row_ff[src_idx]) begin
            r_row_in[src_idx] = 1'b1;
            resume_in         = 1'b1;
            if (src_cnt_ff < cap_eff) begin
               src_cnt_in = src_cnt_ff + 1'b1;
               if (same_port) dst_cnt_in = src_cnt_ff + 1'b1;
            end else begin
               cdrop_in = 1'b1;
            end
         end
      end

      if (cmd.step_data) begin
         if (dst_cnt_ff < cap_eff) begin
            dst_cnt_in = dst_cnt_ff + 1'b1;
         end else begin
            ddrop_in = 1'b1;
         end
      end

      if (cmd.step_deq) begin
         if (dst_cnt_ff != '0) begin
            dst_cnt_in = dst_cnt_ff - 1'b1;
            sent_in    = 1'b1;
         end
      end

      if (cmd.step_flag) begin
         if (action_ff == ACT_PAUSE_DONE) begin
            p_row_in[src_idx] = 1'b0;
         end else begin
            r_row_in[src_idx] = 1'b0;
         end
      end
   end

   // write-back: source count with flag row, then destination count
   assign occ_we    = (cmd.wr_src || cmd.wr_dst) && in_range_ff;
   assign occ_waddr = cmd.wr_src ? src_idx : dst_idx;
   assign occ_wdata = cmd.wr_src ? src_cnt_ff : dst_cnt_ff;
   assign flag_we   = cmd.wr_src && in_range_ff;

   always_comb begin
      occ_valid_in  = occ_valid_ff;
      flag_valid_in = flag_valid_ff;
      if (occ_we) occ_valid_in[occ_waddr] = 1'b1;
      if (flag_we) flag_valid_in[dst_idx] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_dst_ff  <= occ_mem[req_dst_idx];
         rd_src_ff  <= occ_mem[req_src_idx];
         rd_flag_ff <= flag_mem[req_dst_idx];
      end
      if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
      if (flag_we) flag_mem[dst_idx] <= {r_row_ff, p_row_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_valid_ff  <= '0;
         flag_valid_ff <= '0;
         capacity_ff   <= RST_QUEUE_CAPACITY;
         pause_th_ff   <= RST_PAUSE_THRESHOLD;
         resume_th_ff  <= RST_RESUME_THRESHOLD;
         ecn_cut_ff    <= RST_ECN_CUTOFF;
      end else begin
         occ_valid_ff  <= occ_valid_in;
         flag_valid_ff <= flag_valid_in;
         capacity_ff   <= capacity_in;
         pause_th_ff   <= pause_th_in;
         resume_th_ff  <= resume_th_in;
         ecn_cut_ff    <= ecn_cut_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      dst_ff      <= dst_in;
      src_ff      <= src_in;
      in_range_ff <= in_range_in;
      dst_cnt_ff  <= dst_cnt_in;
      src_cnt_ff  <= src_cnt_in;
      p_row_ff    <= p_row_in;
      r_row_ff    <= r_row_in;
      ecn_ff      <= ecn_in;
      pause_ff    <= pause_in;
      resume_ff   <= resume_in;
      cdrop_ff    <= cdrop_in;
      ddrop_ff    <= ddrop_in;
      sent_ff     <= sent_in;
   end

   assign stat.in_range = in_range_ff;
   assign stat.action   = action_ff;

   assign rsp_ecn_mark        = ecn_ff;
   assign rsp_pause_out       = pause_ff;
   assign rsp_resume_out      = resume_ff;
   assign rsp_control_dropped = cdrop_ff;
   assign rsp_data_dropped    = ddrop_ff;
   assign rsp_frame_sent      = sent_ff;
   assign rsp_occupancy_after = in_range_ff ? dst_cnt_ff : '0;

endmodule

FILE: hdl/pfc_ecn_egress_admission_unit.sv
// top level of the pfc/ecn egress admission unit
//
//   channel   handshake              payload
//   request   start / busy           req_action, req_dest_port, req_source_port
//   response  rsp_valid strobe       rsp_ecn_mark .. rsp_occupancy_after
//   csr       csr_valid / csr_ready  csr_index, csr_data
//
// a request is taken when start is high and busy low; busy stays high until the
// response strobe; arrivals run pause, resume and data steps, dequeues a dequeue
// step, pause/resume deliveries a flag step, each between load and both writes on
// one occupancy write port; requests with a port >= PORTS run load and the
// destination write; synchronous reset clears sequencer and per-row valid bits,
// reloads config registers; csr_ready is always high; responses cannot be stalled
module pfc_ecn_egress_admission_unit #(
   parameter int PORTS       = 16,
   parameter int QUEUE_DEPTH = 8192
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [pfc_adm_pkg::ACTION_W-1:0]       req_action,
   input  logic [pfc_adm_pkg::PORT_FW-1:0]        req_dest_port,
   input  logic [pfc_adm_pkg::PORT_FW-1:0]        req_source_port,
   output logic                                   rsp_valid,
   output logic                                   rsp_ecn_mark,
   output logic                                   rsp_pause_out,
   output logic                                   rsp_resume_out,
   output logic                                   rsp_control_dropped,
   output logic                                   rsp_data_dropped,
   output logic                                   rsp_frame_sent,
   output logic [pfc_adm_pkg::CNT_W-1:0]          rsp_occupancy_after,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pfc_adm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pfc_adm_pkg::CNT_W-1:0]          csr_data
);
   import pfc_adm_pkg::*;

   `include "assert_macros.svh"

   cmd_type  cmd;
   stat_type stat;
   logic     csr_we;
   logic     ctrl_frame;
   logic     arrival_flags;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   assign ctrl_frame    = rsp_pause_out || rsp_resume_out;
   assign arrival_flags = rsp_ecn_mark || rsp_data_dropped || rsp_pause_out;

   pfc_adm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   pfc_adm_dp #(
      .PORTS       (PORTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_action          (req_action),
      .req_dest_port       (req_dest_port),
      .req_source_port     (req_source_port),
      .rsp_ecn_mark        (rsp_ecn_mark),
      .rsp_pause_out       (rsp_pause_out),
      .rsp_resume_out      (rsp_resume_out),
      .rsp_control_dropped (rsp_control_dropped),
      .rsp_data_dropped    (rsp_data_dropped),
      .rsp_frame_sent      (rsp_frame_sent),
      .rsp_occupancy_after (rsp_occupancy_after)
   );

   `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `ASSERT_NEXT(a_rsp_then_idle, rsp_valid, !busy)
   `ASSERT_HOLDS(a_drop_needs_ctrl, rsp_valid && rsp_control_dropped, ctrl_frame)
   `ASSERT_HOLDS(a_sent_only_deq, rsp_valid && rsp_frame_sent, !arrival_flags)

endmodule

FILE: bench/tb.sv
// self-checking testbench for the pfc/ecn egress admission unit
`timescale 1ns / 1ps

module tb;
   import pfc_adm_pkg::*;

   localparam int PORTS         = 16;
   localparam int QUEUE_DEPTH   = 8192;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 200;
   localparam int DRAIN_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic             ecn_mark;
      logic             pause_out;
      logic             resume_out;
      logic             control_dropped;
      logic             data_dropped;
      logic             frame_sent;
      logic [CNT_W-1:0] occupancy_after;
   } verdict_type;

   class admission_scoreboard;
      int unsigned queue_capacity;
      int unsigned pause_threshold;
      int unsigned resume_threshold;
      int unsigned ecn_cutoff;
      int unsigned occupancy [PORTS];
      bit          pause_sent [PORTS*PORTS];
      bit          resume_sent [PORTS*PORTS];
      verdict_type pending_verdicts [$];
      int          mismatches;
      int          responses_checked;

      function new();
         queue_capacity   = 32'(RST_QUEUE_CAPACITY);
         pause_threshold  = 32'(RST_PAUSE_THRESHOLD);
         resume_threshold = 32'(RST_RESUME_THRESHOLD);
         ecn_cutoff       = 32'(RST_ECN_CUTOFF);
         foreach (occupancy[i]) occupancy[i] = 0;
         foreach (pause_sent[i]) pause_sent[i] = 1'b0;
         foreach (resume_sent[i]) resume_sent[i] = 1'b0;
         mismatches        = 0;
         responses_checked = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
         case (idx)
            CSR_QUEUE_CAPACITY:   queue_capacity   = 32'(value);
            CSR_PAUSE_THRESHOLD:  pause_threshold  = 32'(value);
            CSR_RESUME_THRESHOLD: resume_threshold = 32'(value);
            CSR_ECN_CUTOFF:       ecn_cutoff       = 32'(value);
            default: ;
         endcase
      endfunction

      function bit admit_frame(int unsigned port);
         int unsigned cap;
         cap = (queue_capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : queue_capacity;
         if (occupancy[port] >= cap) return 1'b0;
         occupancy[port]++;
         return 1'b1;
      endfunction

      function void note_request(action_type act, logic [PORT_FW-1:0] dst,
                                 logic [PORT_FW-1:0] src);
         verdict_type v;
         int unsigned pair;
         v    = '0;
         pair = dst * PORTS + src;
         case (act)
            ACT_ARRIVAL: begin
               if (occupancy[dst] > ecn_cutoff) v.ecn_mark = 1'b1;
               if (occupancy[dst] >= pause_threshold && !pause_sent[pair]) begin
                  pause_sent[pair] = 1'b1;
                  v.pause_out      = 1'b1;
                  if (!admit_frame(src)) v.control_dropped = 1'b1;
               end
               if (occupancy[dst] < resume_threshold && !resume_sent[pair]) begin
                  resume_sent[pair] = 1'b1;
                  v.resume_out      = 1'b1;
                  if (!admit_frame(src)) v.control_dropped = 1'b1;
               end
               if (!admit_frame(dst)) v.data_dropped = 1'b1;
            end
            ACT_DEQUEUE: begin
               if (occupancy[dst] > 0) begin
                  occupancy[dst]--;
                  v.frame_sent = 1'b1;
               end
            end
            ACT_PAUSE_DONE:  pause_sent[pair] = 1'b0;
            ACT_RESUME_DONE: resume_sent[pair] = 1'b0;
            default: ;
         endcase
         v.occupancy_after = occupancy[dst][CNT_W-1:0];
         pending_verdicts.push_back(v);
      endfunction

      function void compare_field(string name, int unsigned exp, int unsigned act);
         if (exp != act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            mismatches++;
         end
      endfunction

      function void check_response(verdict_type got);
         verdict_type exp;
         if (pending_verdicts.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
            return;
         end
         exp = pending_verdicts.pop_front();
         responses_checked++;
         compare_field("ecn_mark", exp.ecn_mark, got.ecn_mark);
         compare_field("pause_out", exp.pause_out, got.pause_out);
         compare_field("resume_out", exp.resume_out, got.resume_out);
         compare_field("control_dropped", exp.control_dropped, got.control_dropped);
         compare_field("data_dropped", exp.data_dropped, got.data_dropped);
         compare_field("frame_sent", exp.frame_sent, got.frame_sent);
         compare_field("occupancy_after", exp.occupancy_after, got.occupancy_after);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [ACTION_W-1:0]  req_action;
   logic [PORT_FW-1:0]   req_dest_port;
   logic [PORT_FW-1:0]   req_source_port;
   logic                 rsp_valid;
   logic                 rsp_ecn_mark;
   logic                 rsp_pause_out;
   logic                 rsp_resume_out;
   logic                 rsp_control_dropped;
   logic                 rsp_data_dropped;
   logic                 rsp_frame_sent;
   logic [CNT_W-1:0]     rsp_occupancy_after;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CNT_W-1:0]     csr_data;

   admission_scoreboard sb;
   int                  cycle_count;
   int                  requests_sent;
   int                  settings_applied;

   pfc_ecn_egress_admission_unit #(
      .PORTS       (PORTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_dest_port       (req_dest_port),
      .req_source_port     (req_source_port),
      .rsp_valid           (rsp_valid),
      .rsp_ecn_mark        (rsp_ecn_mark),
      .rsp_pause_out       (rsp_pause_out),
      .rsp_resume_out      (rsp_resume_out),
      .rsp_control_dropped (rsp_control_dropped),
      .rsp_data_dropped    (rsp_data_dropped),
      .rsp_frame_sent      (rsp_frame_sent),
      .rsp_occupancy_after (rsp_occupancy_after),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_response({rsp_ecn_mark, rsp_pause_out, rsp_resume_out, rsp_control_dropped,
                            rsp_data_dropped, rsp_frame_sent, rsp_occupancy_after});
      end
   end

   task automatic send_request(input action_type act, input logic [PORT_FW-1:0] dst,
                               input logic [PORT_FW-1:0] src);
      req_action      <= act;
      req_dest_port   <= dst;
      req_source_port <= src;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(act, dst, src);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic hold_off_requests(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (sb.pending_verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [CNT_W-1:0] cap, input logic [CNT_W-1:0] pz,
                                 input logic [CNT_W-1:0] rz, input logic [CNT_W-1:0] ez);
      wait_idle();
      write_csr(CSR_QUEUE_CAPACITY, cap);
      write_csr(CSR_PAUSE_THRESHOLD, pz);
      write_csr(CSR_RESUME_THRESHOLD, rz);
      write_csr(CSR_ECN_CUTOFF, ez);
      settings_applied++;
   endtask

   initial begin
      int                 cap;
      int                 arrival_pct;
      int                 dequeue_pct;
      int                 idle_pct;
      int                 r;
      logic [PORT_FW-1:0] hot_dst;
      logic [PORT_FW-1:0] hot_src;
      logic [PORT_FW-1:0] dst;
      logic [PORT_FW-1:0] src;
      action_type         act;

      sb               = new();
      cycle_count      = 0;
      requests_sent    = 0;
      settings_applied = 1;
      reset            = 1'b1;
      start            = 1'b0;
      req_action       = ACT_ARRIVAL;
      req_dest_port    = '0;
      req_source_port  = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_QUEUE_CAPACITY;
      csr_data         = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: resume generation, flag clearing, empty dequeue
      send_request(ACT_ARRIVAL, 4'd0, 4'd1);
      send_request(ACT_ARRIVAL, 4'd0, 4'd1);
      send_request(ACT_RESUME_DONE, 4'd0, 4'd1);
      send_request(ACT_ARRIVAL, 4'd0, 4'd1);
      send_request(ACT_DEQUEUE, 4'd2, 4'd0);
      send_request(ACT_DEQUEUE, 4'd0, 4'd15);
      send_request(ACT_PAUSE_DONE, 4'd0, 4'd1);
      send_request(ACT_ARRIVAL, 4'd15, 4'd15);

      // tiny queues, both thresholds met, full queues
      apply_settings(14'd2, 14'd0, 14'd16383, 14'd0);
      send_request(ACT_ARRIVAL, 4'd3, 4'd4);
      send_request(ACT_ARRIVAL, 4'd3, 4'd4);
      send_request(ACT_ARRIVAL, 4'd3, 4'd4);
      send_request(ACT_PAUSE_DONE, 4'd3, 4'd4);
      send_request(ACT_RESUME_DONE, 4'd3, 4'd4);
      send_request(ACT_ARRIVAL, 4'd3, 4'd4);
      send_request(ACT_ARRIVAL, 4'd6, 4'd6);

      // zero capacity drops everything
      apply_settings(14'd0, 14'd0, 14'd16383, 14'd0);
      send_request(ACT_ARRIVAL, 4'd7, 4'd8);

      // capacity above queue depth is clamped
      apply_settings(14'd16383, 14'd8192, 14'd0, 14'd16383);
      send_request(ACT_ARRIVAL, 4'd9, 4'd10);
      send_request(ACT_DEQUEUE, 4'd9, 4'd10);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: apply_settings(RST_QUEUE_CAPACITY, RST_PAUSE_THRESHOLD,
                              RST_RESUME_THRESHOLD, RST_ECN_CUTOFF);
            1: apply_settings(14'd1, 14'd0, 14'd16383, 14'd0);
            5: apply_settings(14'd16383, 14'd8192, 14'd0, 14'd8192);
            default: begin
               cap = $urandom_range(48, 1);
               apply_settings(CNT_W'(cap), CNT_W'($urandom_range(cap + 2, 0)),
                              CNT_W'($urandom_range(cap + 2, 0)),
                              CNT_W'($urandom_range(cap, 0)));
            end
         endcase
         arrival_pct = $urandom_range(65, 45);
         dequeue_pct = $urandom_range(35, 20);
         idle_pct    = (p == 3 || p == PHASE_COUNT - 1) ? 0 : 15;
         hot_dst     = PORT_FW'($urandom_range(PORTS - 1, 0));
         hot_src     = PORT_FW'($urandom_range(PORTS - 1, 0));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = $urandom_range(99, 0);
            if (r < arrival_pct) act = ACT_ARRIVAL;
            else if (r < arrival_pct + dequeue_pct) act = ACT_DEQUEUE;
            else if ($urandom_range(1, 0) == 0) act = ACT_PAUSE_DONE;
            else act = ACT_RESUME_DONE;
            dst = ($urandom_range(3, 0) != 0) ? hot_dst : PORT_FW'($urandom_range(PORTS - 1, 0));
            r   = $urandom_range(99, 0);
            if (r < 15) src = dst;
            else if (r < 70) src = hot_src;
            else src = PORT_FW'($urandom_range(PORTS - 1, 0));
            if ($urandom_range(99, 0) < idle_pct) hold_off_requests($urandom_range(13, 1));
            send_request(act, dst, src);
         end
      end

      wait_idle();
      $display("%0d requests sent under %0d register settings, %0d responses checked",
               requests_sent, settings_applied, sb.responses_checked);
      if (sb.pending_verdicts.size() != 0) begin
         $error("%0d responses never arrived", sb.pending_verdicts.size());
         sb.mismatches++;
      end
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pfc_adm_pkg.sv
hdl/pfc_adm_ctrl.sv
hdl/pfc_adm_dp.sv
hdl/pfc_ecn_egress_admission_unit.sv
bench/tb.sv
